>>> design/fpa_pkg.sv
`default_nettype none

package fpa_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int ADDR_BITS = 48;

    localparam int IDX_BITS  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_BITS  = $clog2(MAX_SLOTS + 1);
    localparam int SIZE_BITS = 17;
    localparam int COUNT_BITS = 11;
    localparam int REM_BITS  = SIZE_BITS + IDX_BITS;
    localparam int STEP_BITS = (IDX_BITS > 1) ? $clog2(IDX_BITS) : 1;
    localparam int HDR_BYTES = 8;

    localparam int OP_BITS     = 2;
    localparam int STATUS_BITS = 3;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = ADDR_BITS;

    localparam logic [OP_BITS-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_BITS-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_CHECK = 2'd2;

    localparam logic [STATUS_BITS-1:0] STAT_OK       = 3'd0;
    localparam logic [STATUS_BITS-1:0] STAT_EMPTY    = 3'd1;
    localparam logic [STATUS_BITS-1:0] STAT_BAD_ADDR = 3'd2;
    localparam logic [STATUS_BITS-1:0] STAT_NOT_ALLOC = 3'd3;
    localparam logic [STATUS_BITS-1:0] STAT_IN_USE   = 3'd4;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SLOT_BASE  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SLOT_SIZE  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SLOT_COUNT = 2'd2;

    localparam logic [ADDR_BITS-1:0]  RST_SLOT_BASE  = '0;
    localparam logic [SIZE_BITS-1:0]  RST_SLOT_SIZE  = 17'd16;
    localparam logic [COUNT_BITS-1:0] RST_SLOT_COUNT = 11'd1024;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ALLOC_STK,
        ST_ALLOC_RD,
        ST_ALLOC_MARK,
        ST_ALLOC_ADDR,
        ST_FREE_PREP,
        ST_FREE_RANGE,
        ST_FREE_DIV,
        ST_FREE_CHK,
        ST_FREE_RD,
        ST_FREE_MARK,
        ST_DONE
    } fpa_state_t;

endpackage

`default_nettype wire

>>> design/fpa_if.sv
`default_nettype none

interface fpa_req_if;
    import fpa_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [OP_BITS-1:0]   operation;
    logic [ADDR_BITS-1:0] address;
    modport source (output valid, output operation, output address, input ready);
    modport sink   (input valid, input operation, input address, output ready);
endinterface

interface fpa_rsp_if;
    import fpa_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic [ADDR_BITS-1:0]   result_address;
    logic [IDX_BITS-1:0]    slot_index;
    modport source (output valid, output status, output result_address, output slot_index,
                    input ready);
    modport sink   (input valid, input status, input result_address, input slot_index,
                    output ready);
endinterface

interface fpa_cfg_if;
    import fpa_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/fpa_ram.sv
`default_nettype none

module fpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> design/fixed_slot_pool_allocator.sv
// alloc states: stack pop, used read, mark, address, done (a fresh slot skips pop and read)
// free: prep, range, restoring divide (one quotient bit per cycle), check, used read, mark, done
// check goes straight to done; a request is taken only in idle, and done holds while the response
// register is full; a new request is taken while the previous response waits
// rst_n asynchronous active low: counters, used count and config return to defaults
// no clearing pass: used marks beyond the fresh-slot mark read as clear
`default_nettype none

module fixed_slot_pool_allocator (
    input  wire logic  clk,
    input  wire logic  rst_n,
    fpa_req_if.sink    req,
    fpa_rsp_if.source  rsp,
    fpa_cfg_if.sink    cfg
);
    import fpa_pkg::*;

    fpa_state_t state_reg, state_next;

    logic [ADDR_BITS-1:0]  base_reg;
    logic [SIZE_BITS-1:0]  size_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0]   eff_count;

    logic [CNT_BITS-1:0]  depth_reg, depth_next;
    logic [CNT_BITS-1:0]  fresh_reg, fresh_next;
    logic [CNT_BITS-1:0]  total_reg, total_next;

    logic [ADDR_BITS-1:0] work_reg, work_next;
    logic [REM_BITS-1:0]  rem_reg, rem_next;
    logic [REM_BITS-1:0]  div_reg, div_next;
    logic [IDX_BITS-1:0]  quot_reg, quot_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic [IDX_BITS-1:0]  idx_reg, idx_next;
    logic                 known_free_reg, known_free_next;
    logic [REM_BITS-1:0]  prod_reg, prod_next;

    logic [STATUS_BITS-1:0] res_status_reg, res_status_next;
    logic [ADDR_BITS-1:0]   res_addr_reg, res_addr_next;
    logic [IDX_BITS-1:0]    res_index_reg, res_index_next;

    logic                   out_valid_reg, out_valid_next;
    logic [STATUS_BITS-1:0] out_status_reg, out_status_next;
    logic [ADDR_BITS-1:0]   out_addr_reg, out_addr_next;
    logic [IDX_BITS-1:0]    out_index_reg, out_index_next;

    logic                 stack_we;
    logic [IDX_BITS-1:0]  stack_raddr;
    logic [IDX_BITS-1:0]  stack_rdata;
    logic                 used_we;
    logic                 used_wdata;
    logic                 used_rdata;

    logic [ADDR_BITS:0]   sub_full;
    logic [REM_BITS:0]    trial;
    logic                 used_bit;

    assign eff_count = (32'(count_reg) > MAX_SLOTS) ? CNT_BITS'(MAX_SLOTS)
                                                     : CNT_BITS'(count_reg);
    assign stack_raddr = depth_reg[IDX_BITS-1:0] - IDX_BITS'(1);

    fpa_ram #(.WIDTH(IDX_BITS), .DEPTH(MAX_SLOTS)) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (depth_reg[IDX_BITS-1:0]),
        .wdata (idx_reg),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    fpa_ram #(.WIDTH(1), .DEPTH(MAX_SLOTS)) u_used_ram (
        .clk   (clk),
        .we    (used_we),
        .waddr (idx_reg),
        .wdata (used_wdata),
        .raddr (idx_reg),
        .rdata (used_rdata)
    );

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.result_address = out_addr_reg;
    assign rsp.slot_index = out_index_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= RST_SLOT_BASE;
            size_reg  <= RST_SLOT_SIZE;
            count_reg <= RST_SLOT_COUNT;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_SLOT_BASE:  base_reg  <= cfg.data[ADDR_BITS-1:0];
                CFG_SLOT_SIZE:  size_reg  <= cfg.data[SIZE_BITS-1:0];
                CFG_SLOT_COUNT: count_reg <= cfg.data[COUNT_BITS-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            depth_reg     <= '0;
            fresh_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            fresh_reg     <= fresh_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg       <= work_next;
        rem_reg        <= rem_next;
        div_reg        <= div_next;
        quot_reg       <= quot_next;
        step_reg       <= step_next;
        idx_reg        <= idx_next;
        known_free_reg <= known_free_next;
        prod_reg       <= prod_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_index_reg  <= res_index_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        out_index_reg  <= out_index_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        depth_next      = depth_reg;
        fresh_next      = fresh_reg;
        total_next      = total_reg;
        work_next       = work_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        quot_next       = quot_reg;
        step_next       = step_reg;
        idx_next        = idx_reg;
        known_free_next = known_free_reg;
        prod_next       = prod_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_index_next  = res_index_reg;
        out_valid_next  = out_valid_reg & ~rsp.ready;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_index_next  = out_index_reg;
        stack_we        = 1'b0;
        used_we         = 1'b0;
        used_wdata      = 1'b0;

        sub_full = {1'b0, work_reg} - {1'b0, base_reg};
        trial    = {1'b0, rem_reg} - {1'b0, div_reg};
        used_bit = ~known_free_reg & used_rdata & (CNT_BITS'(idx_reg) < fresh_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    res_status_next = STAT_OK;
                    res_addr_next   = '0;
                    res_index_next  = '0;
                    if (req.operation == OP_ALLOC)
                    begin
                        if (depth_reg != '0)
                        begin
                            state_next = ST_ALLOC_STK;
                        end
                        else if (fresh_reg < eff_count)
                        begin
                            idx_next        = fresh_reg[IDX_BITS-1:0];
                            fresh_next      = fresh_reg + CNT_BITS'(1);
                            known_free_next = 1'b1;
                            state_next      = ST_ALLOC_MARK;
                        end
                        else
                        begin
                            res_status_next = STAT_EMPTY;
                            state_next      = ST_DONE;
                        end
                    end
                    else if (req.operation == OP_FREE)
                    begin
                        work_next  = req.address - ADDR_BITS'(HDR_BYTES);
                        state_next = ST_FREE_PREP;
                    end
                    else
                    begin
                        res_status_next = (total_reg != '0) ? STAT_IN_USE : STAT_OK;
                        state_next      = ST_DONE;
                    end
                end
            end

            ST_ALLOC_STK:
            begin
                idx_next        = stack_rdata;
                depth_next      = depth_reg - CNT_BITS'(1);
                known_free_next = 1'b0;
                state_next      = ST_ALLOC_RD;
            end

            ST_ALLOC_RD:
            begin
                state_next = ST_ALLOC_MARK;
            end

            ST_ALLOC_MARK:
            begin
                used_we    = 1'b1;
                used_wdata = 1'b1;
                if (!used_bit)
                begin
                    total_next = total_reg + CNT_BITS'(1);
                end
                prod_next      = REM_BITS'(idx_reg * size_reg);
                res_index_next = idx_reg;
                state_next     = ST_ALLOC_ADDR;
            end

            ST_ALLOC_ADDR:
            begin
                res_addr_next = base_reg + ADDR_BITS'(prod_reg) + ADDR_BITS'(HDR_BYTES);
                state_next    = ST_DONE;
            end

            ST_FREE_PREP:
            begin
                if (sub_full[ADDR_BITS] || size_reg == '0)
                begin
                    res_status_next = STAT_BAD_ADDR;
                    state_next      = ST_DONE;
                end
                else
                begin
                    work_next  = sub_full[ADDR_BITS-1:0];
                    state_next = ST_FREE_RANGE;
                end
            end

            ST_FREE_RANGE:
            begin
                // quotient must fit the index width
                if (work_reg[ADDR_BITS-1:IDX_BITS] >= (ADDR_BITS-IDX_BITS)'(size_reg))
                begin
                    res_status_next = STAT_BAD_ADDR;
                    state_next      = ST_DONE;
                end
                else
                begin
                    rem_next   = work_reg[REM_BITS-1:0];
                    div_next   = REM_BITS'(size_reg) << (IDX_BITS - 1);
                    quot_next  = '0;
                    step_next  = STEP_BITS'(IDX_BITS - 1);
                    state_next = ST_FREE_DIV;
                end
            end

            ST_FREE_DIV:
            begin
                if (!trial[REM_BITS])
                begin
                    rem_next = trial[REM_BITS-1:0];
                end
                quot_next = {quot_reg[IDX_BITS-2:0], ~trial[REM_BITS]};
                div_next  = div_reg >> 1;
                step_next = step_reg - STEP_BITS'(1);
                if (step_reg == '0)
                begin
                    state_next = ST_FREE_CHK;
                end
            end

            ST_FREE_CHK:
            begin
                if (rem_reg != '0 || CNT_BITS'(quot_reg) >= eff_count)
                begin
                    res_status_next = STAT_BAD_ADDR;
                    state_next      = ST_DONE;
                end
                else
                begin
                    idx_next        = quot_reg;
                    known_free_next = 1'b0;
                    state_next      = ST_FREE_RD;
                end
            end

            ST_FREE_RD:
            begin
                state_next = ST_FREE_MARK;
            end

            ST_FREE_MARK:
            begin
                if (!used_bit)
                begin
                    res_status_next = STAT_NOT_ALLOC;
                end
                else
                begin
                    used_we    = 1'b1;
                    used_wdata = 1'b0;
                    if (total_reg != '0)
                    begin
                        total_next = total_reg - CNT_BITS'(1);
                    end
                    if (depth_reg < CNT_BITS'(MAX_SLOTS))
                    begin
                        stack_we   = 1'b1;
                        depth_next = depth_reg + CNT_BITS'(1);
                    end
                    res_index_next = idx_reg;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_addr_next   = res_addr_reg;
                    out_index_next  = res_index_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/fpa_checker.sv
`default_nettype none

module fpa_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          req_valid,
    input wire logic                          req_ready,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_ready,
    input wire logic [fpa_pkg::STATUS_BITS-1:0] rsp_status,
    input wire logic [fpa_pkg::ADDR_BITS-1:0]   rsp_result_address,
    input wire logic [fpa_pkg::IDX_BITS-1:0]    rsp_slot_index
);
    import fpa_pkg::*;

    // busy while a request is in progress
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_result_address) && $stable(rsp_slot_index))
        else $error("stalled response changed");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != STAT_OK |->
            rsp_result_address == '0 && rsp_slot_index == '0)
        else $error("failed response carries address or index");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_status == STAT_OK || rsp_status == STAT_EMPTY
            || rsp_status == STAT_BAD_ADDR || rsp_status == STAT_NOT_ALLOC
            || rsp_status == STAT_IN_USE)
        else $error("unknown status code");

endmodule

bind fixed_slot_pool_allocator fpa_checker u_fpa_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_status         (rsp.status),
    .rsp_result_address (rsp.result_address),
    .rsp_slot_index     (rsp.slot_index)
);

`default_nettype wire
